[hw/rtl/assert_macros.svh]
// assertion helpers included by the column core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define GRM_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hw/rtl/grm_pkg.sv]
// ----------------------------------------------------------------------------
// grm_pkg
// Types, constants and the quarter-wave sine table of the column ray marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int SCREEN_COLUMNS_DEF = 120;
  localparam int MAX_STEPS_DEF      = 160;
  localparam int VIEW_ROWS_DEF      = 40;

  localparam int MAP_AREA_ROWS = 20;
  localparam int FOV_UNITS     = 8192;
  localparam int STEP_DIV      = 10;
  localparam int STEP_DIVISOR  = 4 * STEP_DIV;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // reciprocal of the step divisor: floor(a/40) = (a * RCP_MUL) >> RCP_SHIFT, a < 2^18
  localparam logic [15:0] RCP_MUL   = 16'd52429;
  localparam int          RCP_SHIFT = 21;
  // bias that keeps the trig value non-negative, a multiple of the divisor
  localparam int          TRIG_BIAS_Q = 410;
  localparam logic [15:0] TRIG_BIAS   = 16'(TRIG_BIAS_Q * STEP_DIVISOR);

  // position width, sized for the largest step count of 1024
  localparam int POS_W = 22;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PLAYER_X    = 3'd0,
    CFG_PLAYER_Y    = 3'd1,
    CFG_VIEW_ANGLE  = 3'd2,
    CFG_MAP_0_3     = 3'd3,
    CFG_MAP_4_7     = 3'd4,
    CFG_MAP_8_11    = 3'd5,
    CFG_MAP_12_15   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] q;
    logic [5:0]              r;
    logic [3:0]              cell_idx;
    logic                    off;
  } axis_step_t;

  function automatic logic [14:0] sine_tab(input logic [4:0] idx);
    logic [14:0] v;
    unique case (idx)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1606;
      5'd2:    v = 15'd3196;
      5'd3:    v = 15'd4756;
      5'd4:    v = 15'd6270;
      5'd5:    v = 15'd7723;
      5'd6:    v = 15'd9102;
      5'd7:    v = 15'd10394;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd12665;
      5'd10:   v = 15'd13623;
      5'd11:   v = 15'd14449;
      5'd12:   v = 15'd15137;
      5'd13:   v = 15'd15679;
      5'd14:   v = 15'd16069;
      5'd15:   v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/grm_mul.sv]
// ----------------------------------------------------------------------------
// grm_mul
// Shared 16x16 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module grm_mul (
  input  logic        clk_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [31:0] p_o
);

  logic [31:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/grm_div.sv]
// ----------------------------------------------------------------------------
// grm_div
// Restoring divider, one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module grm_div #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 9,
  parameter int QUO_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int REM_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = (QUO_W > 2) ? $clog2(QUO_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [SH_W-1:0]  den_q, den_d;
  logic [QUO_W-1:0] quot_q, quot_d;
  logic             ge;

  assign ge = rem_q >= REM_W'(den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W - 1);
      rem_d  = REM_W'(num_i);
      den_d  = SH_W'(den_i) << (QUO_W - 1);
      quot_d = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - REM_W'(den_q);
      end
      quot_d = {quot_q[QUO_W-2:0], ge};
      den_d  = den_q >> 1;
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hw/rtl/grm_axis_step.sv]
// ----------------------------------------------------------------------------
// grm_axis_step
// One march step along one axis: advances the offset quotient and remainder
// by the per-step increment and finds the map cell of the new sample.
// ----------------------------------------------------------------------------
module grm_axis_step
  import grm_pkg::*;
(
  input  logic signed [POS_W-1:0] q_i,
  input  logic [5:0]              r_i,
  input  logic signed [11:0]      qu_i,
  input  logic [5:0]              ru_i,
  input  logic [15:0]             pos_i,
  input  logic                    sub_i,
  output axis_step_t              step_o
);

  logic [6:0]       rs;
  logic             carry;
  logic [POS_W-1:0] q_new;
  logic [POS_W-1:0] v;
  logic [POS_W-1:0] t;

  assign rs    = 7'(r_i) + 7'(ru_i);
  assign carry = rs >= 7'(STEP_DIVISOR);
  assign q_new = POS_W'(q_i) + POS_W'(qu_i) + POS_W'(carry);
  assign v     = sub_i ? (POS_W'(pos_i) - q_new) : (POS_W'(pos_i) + q_new);
  assign t     = v + POS_W'(2048);

  assign step_o.q        = $signed(q_new);
  assign step_o.r        = carry ? 6'(rs - 7'(STEP_DIVISOR)) : 6'(rs);
  assign step_o.cell_idx = t[15:12];
  // off map when the cell is negative, zero or sixteen and above
  assign step_o.off      = (t[POS_W-1:16] != '0) || (t[15:12] == 4'd0);

endmodule

[hw/rtl/grid_ray_march_column_core.sv]
// ----------------------------------------------------------------------------
// grid_ray_march_column_core
// Casts one ray per screen column through a 16x16 wall map and returns the
// step count, the hit flag and the wall slice rows. A column is taken only
// while the sequencer is idle; the result sits in an output register, so a
// new column may start while the last result waits. Each column is accepted,
// then passes sine lookup and reciprocal scaling through the one shared
// multiplier (S_SIN_MUL, S_SIN_ADD, S_RCP_MUL, S_RCP_SPLIT, per axis), the
// march at one step per cycle (1 to MAX_STEPS steps), the bit-serial row
// divider, and S_FIN, which loads the output register once it is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_ray_march_column_core
  import grm_pkg::*;
#(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int MAX_STEPS      = MAX_STEPS_DEF,
  parameter int VIEW_ROWS      = VIEW_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [6:0]            column_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [5:0]            ceiling_row_o,
  output logic [5:0]            floor_row_o,
  output logic [7:0]            hit_steps_o,
  output logic                  wall_hit_o
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int NUM_W  = $clog2(VIEW_ROWS * MAX_STEPS + 1);
  localparam int DEN_W  = STEP_W + 1;
  localparam int QUO_W  = $clog2(VIEW_ROWS / 2 + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SIN_MUL   = 3'd1;
  localparam logic [2:0] S_SIN_ADD   = 3'd2;
  localparam logic [2:0] S_RCP_MUL   = 3'd3;
  localparam logic [2:0] S_RCP_SPLIT = 3'd4;
  localparam logic [2:0] S_MARCH     = 3'd5;
  localparam logic [2:0] S_DIV       = 3'd6;
  localparam logic [2:0] S_FIN       = 3'd7;

  // configuration
  logic [15:0]  player_x_q, player_y_q, view_angle_q;
  logic [255:0] map_q;

  // sequencer and datapath registers
  logic [2:0]              state_q, state_d;
  logic [15:0]             ray_q, ray_d;
  logic                    axis_q, axis_d;
  logic signed [15:0]      trig_q, trig_d;
  logic signed [11:0]      qux_q, qux_d, quy_q, quy_d;
  logic [5:0]              rux_q, rux_d, ruy_q, ruy_d;
  logic signed [POS_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [5:0]              rx_q, rx_d, ry_q, ry_d;
  logic [STEP_W-1:0]       steps_q, steps_d;
  logic                    hit_q, hit_d;
  logic                    out_valid_q, out_valid_d;
  logic [5:0]              ceil_row_q, ceil_row_d, floor_row_q, floor_row_d;
  logic [7:0]              hit_steps_q, hit_steps_d;
  logic                    wall_hit_q, wall_hit_d;

  // column angle offsets
  logic [15:0] col_ofs [128];
  for (genvar k = 0; k < 128; k++) begin : g_col_ofs
    assign col_ofs[k] = 16'((k * FOV_UNITS) / SCREEN_COLUMNS);
  end

  logic [15:0] ray_start;
  assign ray_start = view_angle_q + 16'(FOV_UNITS / 2) - col_ofs[column_i];

  // sine lookup of the current axis
  logic [15:0] ang;
  logic [14:0] xq;
  logic [4:0]  tidx;
  logic [9:0]  frac;
  logic [14:0] tbase;
  logic [10:0] tdiff;
  logic [15:0] mag;
  logic [15:0] sin_val;

  assign ang   = axis_q ? ray_q : (ray_q + QUARTER_TURN);
  assign xq    = ang[14] ? (15'(QUARTER_TURN) - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
  assign tidx  = xq[14:10];
  assign frac  = xq[9:0];
  assign tbase = sine_tab(tidx);
  assign tdiff = (tidx == 5'd16) ? 11'd0 : 11'(sine_tab(5'(tidx + 5'd1)) - tbase);

  // shared multiplier
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [15:0] bias_a;
  logic [10:0] qd;

  assign bias_a = 16'($unsigned(trig_q)) + TRIG_BIAS;
  assign mul_a  = (state_q == S_RCP_MUL) ? bias_a : 16'(tdiff);
  assign mul_b  = (state_q == S_RCP_MUL) ? RCP_MUL : 16'(frac);

  grm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign mag     = 16'(tbase) + 16'((22'(mul_p) + 22'd512) >> 10);
  assign sin_val = ang[15] ? (16'd0 - mag) : mag;
  assign qd      = mul_p[RCP_SHIFT+10:RCP_SHIFT];

  logic signed [11:0] qu_split;
  logic [5:0]         ru_split;
  assign qu_split = $signed(12'({1'b0, qd}) - 12'(TRIG_BIAS_Q));
  assign ru_split = 6'(bias_a - {qd, 5'b0} - {2'b0, qd, 3'b0});

  // march step
  axis_step_t step_x, step_y;

  grm_axis_step u_step_x (
    .q_i    (qx_q),
    .r_i    (rx_q),
    .qu_i   (qux_q),
    .ru_i   (rux_q),
    .pos_i  (player_x_q),
    .sub_i  (1'b0),
    .step_o (step_x)
  );

  grm_axis_step u_step_y (
    .q_i    (qy_q),
    .r_i    (ry_q),
    .qu_i   (quy_q),
    .ru_i   (ruy_q),
    .pos_i  (player_y_q),
    .sub_i  (1'b1),
    .step_o (step_y)
  );

  logic              wall;
  logic [STEP_W-1:0] steps_next;
  logic              stop;

  assign wall       = step_x.off || step_y.off ||
                      map_q[{step_y.cell_idx, step_x.cell_idx}];
  assign steps_next = steps_q + STEP_W'(1);
  assign stop       = wall || (steps_next == STEP_W'(MAX_STEPS));

  // row divider
  logic [NUM_W-1:0] rows_prod;
  logic [NUM_W-1:0] div_num;
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_quot;

  assign rows_prod = NUM_W'(VIEW_ROWS * steps_next);
  assign div_num   = (rows_prod > NUM_W'(2 * STEP_DIV * VIEW_ROWS)) ?
                     (rows_prod - NUM_W'(2 * STEP_DIV * VIEW_ROWS)) : '0;

  grm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({steps_next, 1'b0}),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    ray_d       = ray_q;
    axis_d      = axis_q;
    trig_d      = trig_q;
    qux_d       = qux_q;
    rux_d       = rux_q;
    quy_d       = quy_q;
    ruy_d       = ruy_q;
    qx_d        = qx_q;
    rx_d        = rx_q;
    qy_d        = qy_q;
    ry_d        = ry_q;
    steps_d     = steps_q;
    hit_d       = hit_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q;
    ceil_row_d  = ceil_row_q;
    floor_row_d = floor_row_q;
    hit_steps_d = hit_steps_q;
    wall_hit_d  = wall_hit_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ray_d   = ray_start;
          axis_d  = 1'b0;
          state_d = S_SIN_MUL;
        end
      end
      S_SIN_MUL: begin
        state_d = S_SIN_ADD;
      end
      S_SIN_ADD: begin
        trig_d  = $signed(sin_val);
        state_d = S_RCP_MUL;
      end
      S_RCP_MUL: begin
        state_d = S_RCP_SPLIT;
      end
      S_RCP_SPLIT: begin
        if (!axis_q) begin
          qux_d   = qu_split;
          rux_d   = ru_split;
          axis_d  = 1'b1;
          state_d = S_SIN_MUL;
        end else begin
          quy_d   = qu_split;
          ruy_d   = ru_split;
          qx_d    = '0;
          qy_d    = '0;
          rx_d    = 6'(STEP_DIVISOR / 2);
          ry_d    = 6'(STEP_DIVISOR / 2);
          steps_d = '0;
          state_d = S_MARCH;
        end
      end
      S_MARCH: begin
        qx_d    = step_x.q;
        rx_d    = step_x.r;
        qy_d    = step_y.q;
        ry_d    = step_y.r;
        steps_d = steps_next;
        if (stop) begin
          hit_d     = wall;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ceil_row_d  = 6'(MAP_AREA_ROWS + int'(div_quot));
          floor_row_d = 6'(MAP_AREA_ROWS + VIEW_ROWS - int'(div_quot));
          hit_steps_d = 8'(steps_q);
          wall_hit_d  = hit_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      steps_q      <= '0;
      player_x_q   <= 16'd16384;
      player_y_q   <= 16'd40960;
      view_angle_q <= 16'd16384;
      map_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      steps_q     <= steps_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_PLAYER_X:   player_x_q     <= cfg_wdata_i[15:0];
          CFG_PLAYER_Y:   player_y_q     <= cfg_wdata_i[15:0];
          CFG_VIEW_ANGLE: view_angle_q   <= cfg_wdata_i[15:0];
          CFG_MAP_0_3:    map_q[63:0]    <= cfg_wdata_i;
          CFG_MAP_4_7:    map_q[127:64]  <= cfg_wdata_i;
          CFG_MAP_8_11:   map_q[191:128] <= cfg_wdata_i;
          CFG_MAP_12_15:  map_q[255:192] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q       <= ray_d;
    axis_q      <= axis_d;
    trig_q      <= trig_d;
    qux_q       <= qux_d;
    rux_q       <= rux_d;
    quy_q       <= quy_d;
    ruy_q       <= ruy_d;
    qx_q        <= qx_d;
    rx_q        <= rx_d;
    qy_q        <= qy_d;
    ry_q        <= ry_d;
    hit_q       <= hit_d;
    ceil_row_q  <= ceil_row_d;
    floor_row_q <= floor_row_d;
    hit_steps_q <= hit_steps_d;
    wall_hit_q  <= wall_hit_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign ceiling_row_o = ceil_row_q;
  assign floor_row_o   = floor_row_q;
  assign hit_steps_o   = hit_steps_q;
  assign wall_hit_o    = wall_hit_q;

  `GRM_ASSERT(a_steps_cap, steps_q <= STEP_W'(MAX_STEPS), "step count above cap")
  `GRM_ASSERT(a_march_rem, (state_q == S_MARCH) |-> (rx_q < 6'(STEP_DIVISOR) && ry_q < 6'(STEP_DIVISOR)), "march remainder out of range")
  `GRM_ASSERT(a_cap_steps, (out_valid_o && !wall_hit_o) |-> (hit_steps_o == 8'(MAX_STEPS)), "depth cap result without full step count")
  `GRM_ASSERT(a_row_sum, out_valid_o |-> (6'(ceiling_row_o + floor_row_o) == 6'(2 * MAP_AREA_ROWS + VIEW_ROWS)), "wall slice rows inconsistent")
  `GRM_ASSERT_NEVER(a_div_idle, div_done && (state_q != S_DIV), "divider finished outside its state")

endmodule
